[hdl/pidt_pkg.sv]
package pidt_pkg;

  // Data and accumulator widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D_CURRENT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D_PREVIOUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D_FEEDBACK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_I          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_AW         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN         = 3'd6;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  // Input request: kind 0 = process sample, 1 = clear history
  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] sample;
  } pidt_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     clamped;
  } pidt_out_t;

  // Controls for the shared multiply/add unit
  typedef struct packed {
    logic mul_en;
    logic add_en;
  } pidt_alu_ctl_t;

  // Saturate a wide sum to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > ACC_W'(S32_MAX)) begin
      r = S32_MAX;
    end else if (v < ACC_W'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/pidt_alu.sv]
module pidt_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  pidt_pkg::pidt_alu_ctl_t                ctl,
  input  logic signed [pidt_pkg::DATA_W-1:0]     mul_a,
  input  logic signed [pidt_pkg::DATA_W-1:0]     mul_b,
  input  logic signed [pidt_pkg::ACC_W-1:0]      add_a,
  input  logic signed [pidt_pkg::ACC_W-1:0]      add_b,
  output logic signed [pidt_pkg::ACC_W-1:0]      fx,
  output logic signed [pidt_pkg::ACC_W-1:0]      acc,
  output logic signed [pidt_pkg::DATA_W-1:0]     acc_sat
);
  import pidt_pkg::*;

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;

  // 32x32 signed product, full 64 bits
  assign prod = ACC_W'(mul_a) * ACC_W'(mul_b);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod;
    end
    if (ctl.add_en) begin
      acc_r <= add_a + add_b;
    end
  end

  // Scaled product, floor toward minus infinity
  assign fx      = prod_r >>> FRAC_BITS;
  assign acc     = acc_r;
  assign acc_sat = sat32(acc_r);

endmodule

[hdl/pid_tustin_antiwindup_step.sv]
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   pidt_in_t  {kind, sample}
// out_     output     out_valid / out_stall pidt_out_t {drive, clamped}
// cfg_     input      cfg_we                cfg_index, cfg_data
//
// A sample request runs through an accept step, ten steps of the shared
// multiplier/adder and a final step that loads the output register. A clear
// request goes from its accept step straight to loading the output register.
// The single multiplier and the single 64-bit adder set the rate: five products
// and six saturated sums run one after the other.
// rst_n is synchronous: history clears, coefficients return to their defaults.
// A result waits in the output register while out_stall is high; the block
// holds its last step until that register is free.
module pid_tustin_antiwindup_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pidt_pkg::pidt_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pidt_pkg::pidt_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [pidt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidt_pkg::DATA_W-1:0]         cfg_data
);
  import pidt_pkg::*;

  // Sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M0   = 4'd1;
  localparam logic [3:0] ST_M1   = 4'd2;
  localparam logic [3:0] ST_M2   = 4'd3;
  localparam logic [3:0] ST_M3   = 4'd4;
  localparam logic [3:0] ST_PD   = 4'd5;
  localparam logic [3:0] ST_IIN  = 4'd6;
  localparam logic [3:0] ST_MI   = 4'd7;
  localparam logic [3:0] ST_IO   = 4'd8;
  localparam logic [3:0] ST_SUM  = 4'd9;
  localparam logic [3:0] ST_LIM  = 4'd10;
  localparam logic [3:0] ST_FIN  = 4'd11;
  localparam logic [3:0] ST_CLR  = 4'd12;

  logic [3:0] state_r, state_nxt;

  // Coefficients and limits
  logic signed [DATA_W-1:0] c0_r, c1_r, c2_r, ci_r, caw_r, out_max_r, out_min_r;

  // History
  logic signed [DATA_W-1:0] px_r, ppd_r, pio_r, pcerr_r, piin_r;

  // Per-sample working values
  logic signed [DATA_W-1:0] x_r, pd_r, iin_r, io_r, drive_r;
  logic                     lim_r;

  logic      out_valid_r;
  pidt_out_t out_data_r;

  // Shared unit hookup
  pidt_alu_ctl_t            alu_ctl;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [ACC_W-1:0]  add_a, add_b;
  logic signed [ACC_W-1:0]  fx, acc;
  logic signed [DATA_W-1:0] acc_sat;

  logic signed [DATA_W-1:0] drive_nxt;
  logic                     lim_nxt;
  logic                     out_free;
  logic                     accept;
  logic                     commit;
  logic                     clear;

  pidt_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk    (clk),
    .ctl    (alu_ctl),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .add_a  (add_a),
    .add_b  (add_b),
    .fx     (fx),
    .acc    (acc),
    .acc_sat(acc_sat)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign commit    = (state_r == ST_FIN) && out_free;
  assign clear     = (state_r == ST_CLR) && out_free;

  // Output clamp; upper limit is checked first
  always_comb begin
    if (acc_sat > out_max_r) begin
      drive_nxt = out_max_r;
      lim_nxt   = 1'b1;
    end else if (acc_sat < out_min_r) begin
      drive_nxt = out_min_r;
      lim_nxt   = 1'b1;
    end else begin
      drive_nxt = acc_sat;
      lim_nxt   = 1'b0;
    end
  end

  // Sequencer: operand selection and next state
  always_comb begin
    state_nxt      = state_r;
    alu_ctl.mul_en = 1'b0;
    alu_ctl.add_en = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    add_a          = '0;
    add_b          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_data.kind ? ST_CLR : ST_M0;
        end
      end
      ST_M0: begin
        alu_ctl.mul_en = 1'b1;
        mul_a          = c0_r;
        mul_b          = x_r;
        state_nxt      = ST_M1;
      end
      ST_M1: begin
        alu_ctl.mul_en = 1'b1;
        alu_ctl.add_en = 1'b1;
        mul_a          = c1_r;
        mul_b          = px_r;
        add_b          = fx;
        state_nxt      = ST_M2;
      end
      ST_M2: begin
        alu_ctl.mul_en = 1'b1;
        alu_ctl.add_en = 1'b1;
        mul_a          = c2_r;
        mul_b          = ppd_r;
        add_a          = acc;
        add_b          = fx;
        state_nxt      = ST_M3;
      end
      ST_M3: begin
        // feedback term is subtracted
        alu_ctl.mul_en = 1'b1;
        alu_ctl.add_en = 1'b1;
        mul_a          = caw_r;
        mul_b          = pcerr_r;
        add_a          = acc;
        add_b          = -fx;
        state_nxt      = ST_PD;
      end
      ST_PD: begin
        // pd ready; start integrator input x + caw*cerr
        alu_ctl.add_en = 1'b1;
        add_a          = ACC_W'(x_r);
        add_b          = fx;
        state_nxt      = ST_IIN;
      end
      ST_IIN: begin
        // iin ready; trapezoid sum iin + iin_prev
        alu_ctl.add_en = 1'b1;
        add_a          = ACC_W'(acc_sat);
        add_b          = ACC_W'(piin_r);
        state_nxt      = ST_MI;
      end
      ST_MI: begin
        alu_ctl.mul_en = 1'b1;
        mul_a          = ci_r;
        mul_b          = acc_sat;
        state_nxt      = ST_IO;
      end
      ST_IO: begin
        alu_ctl.add_en = 1'b1;
        add_a          = fx;
        add_b          = ACC_W'(pio_r);
        state_nxt      = ST_SUM;
      end
      ST_SUM: begin
        // io ready; total = pd + io
        alu_ctl.add_en = 1'b1;
        add_a          = ACC_W'(pd_r);
        add_b          = ACC_W'(acc_sat);
        state_nxt      = ST_LIM;
      end
      ST_LIM: begin
        // clamp error = drive - total
        alu_ctl.add_en = 1'b1;
        add_a          = ACC_W'(drive_nxt);
        add_b          = -ACC_W'(acc_sat);
        state_nxt      = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLR: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control, configuration and history registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      c0_r        <= '0;
      c1_r        <= '0;
      c2_r        <= '0;
      ci_r        <= '0;
      caw_r       <= '0;
      out_max_r   <= S32_MAX;
      out_min_r   <= S32_MIN;
      px_r        <= '0;
      ppd_r       <= '0;
      pio_r       <= '0;
      pcerr_r     <= '0;
      piin_r      <= '0;
    end else begin
      state_r <= state_nxt;

      if (commit || clear) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_COEF_D_CURRENT:  c0_r      <= cfg_data;
          REG_COEF_D_PREVIOUS: c1_r      <= cfg_data;
          REG_COEF_D_FEEDBACK: c2_r      <= cfg_data;
          REG_COEF_I:          ci_r      <= cfg_data;
          REG_COEF_AW:         caw_r     <= cfg_data;
          REG_OUT_MAX:         out_max_r <= cfg_data;
          REG_OUT_MIN:         out_min_r <= cfg_data;
          default: ;
        endcase
      end

      if (commit) begin
        px_r    <= x_r;
        ppd_r   <= pd_r;
        pio_r   <= io_r;
        piin_r  <= iin_r;
        pcerr_r <= acc_sat;
      end else if (clear) begin
        px_r    <= '0;
        ppd_r   <= '0;
        pio_r   <= '0;
        piin_r  <= '0;
        pcerr_r <= '0;
      end
    end
  end

  // Working values and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_data.sample;
    end
    if (state_r == ST_PD) begin
      pd_r <= acc_sat;
    end
    if (state_r == ST_IIN) begin
      iin_r <= acc_sat;
    end
    if (state_r == ST_SUM) begin
      io_r <= acc_sat;
    end
    if (state_r == ST_LIM) begin
      drive_r <= drive_nxt;
      lim_r   <= lim_nxt;
    end
    if (commit) begin
      out_data_r.drive   <= drive_r;
      out_data_r.clamped <= lim_r;
    end else if (clear) begin
      out_data_r.drive   <= '0;
      out_data_r.clamped <= 1'b0;
    end
  end

endmodule
